// ===== sv/sts_pkg.sv =====
// Package for the seek target step unit: widths, reset values and opcodes.
// Used by the serial arithmetic unit, the top level and the testbench.
package sts_pkg;

   localparam int CoordWidth  = 32;
   localparam int SpeedWidth  = 24;
   localparam int RadiusWidth = 31;
   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 32;

   localparam logic [SpeedWidth-1:0]  SpeedReset  = 24'd196608;
   localparam logic [RadiusWidth-1:0] RadiusReset = 31'd65536;

   localparam logic [1:0] FN_MUL  = 2'd0;
   localparam logic [1:0] FN_DIV  = 2'd1;
   localparam logic [1:0] FN_SQRT = 2'd2;

   typedef enum logic [1:0] {
      OP_STEP     = 2'd0,
      OP_LOAD_POS = 2'd1,
      OP_LOAD_VEL = 2'd2,
      OP_NONE     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_TARGET_X = 2'd0,
      CSR_TARGET_Y = 2'd1,
      CSR_SPEED    = 2'd2,
      CSR_RADIUS   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [SpeedWidth-1:0] delta_time;
      logic [CoordWidth-1:0] value_x;
      logic [CoordWidth-1:0] value_y;
   } req_type;

   typedef struct packed {
      logic [CoordWidth-1:0] pos_x;
      logic [CoordWidth-1:0] pos_y;
      logic [CoordWidth-1:0] vel_x;
      logic [CoordWidth-1:0] vel_y;
      logic                  at_target;
   } rsp_type;

endpackage

// ===== sv/sts_stream_if.sv =====
// Valid/ready channel interface carrying one request or result payload.
// Depends on sts_pkg for nothing but is kept generic over the payload type.
interface sts_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/sts_serial_unit.sv =====
// Bit-serial arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one bit per cycle. Depends on sts_pkg.
module sts_serial_unit
   import sts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   op_in,
   input  logic         start,
   input  logic [65:0]  a_in,
   input  logic [65:0]  b_in,
   output logic         done,
   output logic [65:0]  result
);

   logic [1:0]  fn_ff, fn_in;
   logic        busy_ff, busy_in;
   logic [6:0]  count_ff, count_in;
   logic [65:0] a_ff, a_next;
   logic [65:0] b_ff, b_next;
   logic [67:0] acc_ff, acc_next;
   logic [65:0] res_ff, res_next;
   logic [67:0] trial;
   logic [67:0] rem_shift;

   always_comb begin
      fn_in    = fn_ff;
      busy_in  = busy_ff;
      count_in = count_ff;
      a_next   = a_ff;
      b_next   = b_ff;
      acc_next = acc_ff;
      res_next = res_ff;
      done     = 1'b0;
      trial    = '0;
      rem_shift = '0;
      if (busy_ff) begin
         case (fn_ff)
            FN_MUL: begin
               // a is multiplicand shifting left, b multiplier shifting right.
               if (b_ff[0]) begin
                  res_next = res_ff + a_ff;
               end
               a_next = {a_ff[64:0], 1'b0};
               b_next = {1'b0, b_ff[65:1]};
            end
            FN_DIV: begin
               rem_shift = {acc_ff[66:0], a_ff[65]};
               a_next    = {a_ff[64:0], 1'b0};
               if (rem_shift >= {2'b00, b_ff}) begin
                  acc_next = rem_shift - {2'b00, b_ff};
                  res_next = {res_ff[64:0], 1'b1};
               end else begin
                  acc_next = rem_shift;
                  res_next = {res_ff[64:0], 1'b0};
               end
            end
            FN_SQRT: begin
               rem_shift = {acc_ff[65:0], a_ff[65:64]};
               a_next    = {a_ff[63:0], 2'b00};
               trial     = {res_ff, 2'b01};
               if (rem_shift >= trial) begin
                  acc_next = rem_shift - trial;
                  res_next = {res_ff[64:0], 1'b1};
               end else begin
                  acc_next = rem_shift;
                  res_next = {res_ff[64:0], 1'b0};
               end
            end
            default: begin
               res_next = '0;
            end
         endcase
         count_in = count_ff - 7'd1;
         if (count_ff == 7'd1) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
      result = res_next;
      if (start) begin
         fn_in    = op_in;
         busy_in  = 1'b1;
         a_next   = a_in;
         b_next   = b_in;
         acc_next = '0;
         res_next = '0;
         count_in = (op_in == FN_SQRT) ? 7'd33 : 7'd66;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
         fn_ff    <= FN_MUL;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
         fn_ff    <= fn_in;
      end
      a_ff   <= a_next;
      b_ff   <= b_next;
      acc_ff <= acc_next;
      res_ff <= res_next;
   end

endmodule

// ===== sv/seek_target_step_unit.sv =====
// Top level of the seek target step unit: request and result channels,
// register port, state and sequencer. Depends on sts_pkg, sts_stream_if
// and sts_serial_unit.
//
// Usage: configure target, speed and arrival radius through the csr_
// write port while idle. Each request on req_ carries an opcode: a step
// moves the point toward the target by speed times delta_time, the load
// opcodes set position or velocity. Every request yields exactly one
// result on rsp_ with position, velocity and the at-target flag.
// A load, an unused opcode or a step at the target shows its result once
// the arrival check has run: two squares on one bit-serial unit. A step that
// moves runs the check, a square root, four products and two 66-bit
// divisions, then the arrival check again on the new position. A step
// exactly on the target with a zero radius runs the check, a square root of
// zero, which clears the velocity, and then the check again.
// One request is in flight at a time; the next can be accepted in the cycle
// after the result is taken. Reset clears position, velocity and target to zero,
// speed to 3.0 and radius to 1.0. The result stays in an output register
// until taken; while it waits no new request is accepted.
module seek_target_step_unit
   import sts_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   sts_stream_if.sink                req,
   sts_stream_if.source              rsp,
   input  logic                      csr_write_enable,
   input  logic [CsrAddrWidth-1:0]   csr_index,
   input  logic [CsrDataWidth-1:0]   csr_write_data
);

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_SQX   = 14'b00000000000010,
      ST_SQY   = 14'b00000000000100,
      ST_SQRT  = 14'b00000000001000,
      ST_MULX  = 14'b00000000010000,
      ST_DIVX  = 14'b00000000100000,
      ST_MULY  = 14'b00000001000000,
      ST_DIVY  = 14'b00000010000000,
      ST_MVX   = 14'b00000100000000,
      ST_MVY   = 14'b00001000000000,
      ST_CHKX  = 14'b00010000000000,
      ST_CHKY  = 14'b00100000000000,
      ST_CHK   = 14'b01000000000000,
      ST_OUT   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [CoordWidth-1:0] tx_ff, ty_ff;
   logic [SpeedWidth-1:0]        speed_ff;
   logic [RadiusWidth-1:0]       radius_ff;
   logic signed [CoordWidth-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [CoordWidth-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [SpeedWidth-1:0]        dt_ff, dt_in;
   logic                         step_ff, step_in;
   logic [65:0]                  sx_ff, sx_in;
   logic [65:0]                  dist_ff, dist_in;
   logic                         near_ff, near_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [1:0]  u_op;
   logic        u_start;
   logic [65:0] u_a, u_b, u_res;
   logic        u_done;

   logic signed [32:0] dx, dy;
   logic [32:0]        ax, ay, avx, avy;
   logic [65:0]        r_sq;
   logic signed [33:0] sum_x, sum_y;
   logic signed [32:0] qs;

   sts_serial_unit u_serial (
      .clock  (clock),
      .reset  (reset),
      .op_in  (u_op),
      .start  (u_start),
      .a_in   (u_a),
      .b_in   (u_b),
      .done   (u_done),
      .result (u_res)
   );

   always_comb begin
      dx  = 33'(tx_ff) - 33'(px_ff);
      dy  = 33'(ty_ff) - 33'(py_ff);
      ax  = dx[32] ? 33'(-dx) : 33'(dx);
      ay  = dy[32] ? 33'(-dy) : 33'(dy);
      avx = vx_ff[31] ? 33'(-33'(vx_ff)) : 33'(vx_ff);
      avy = vy_ff[31] ? 33'(-33'(vy_ff)) : 33'(vy_ff);
      r_sq = 66'(radius_ff) * 66'(radius_ff);
   end

   function automatic logic signed [31:0] sat(input logic signed [33:0] s);
      if (s > 34'sd2147483647) begin
         sat = 32'sh7fffffff;
      end else if (s < -34'sd2147483648) begin
         sat = 32'sh80000000;
      end else begin
         sat = s[31:0];
      end
   endfunction

   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      dt_in        = dt_ff;
      step_in      = step_ff;
      sx_in        = sx_ff;
      dist_in      = dist_ff;
      near_in      = near_ff;
      rsp_valid_in = rsp_valid_ff;
      u_op         = FN_MUL;
      u_start      = 1'b0;
      u_a          = '0;
      u_b          = '0;
      qs           = '0;
      sum_x        = '0;
      sum_y        = '0;
      req.ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               dt_in   = req.data.delta_time;
               step_in = 1'b0;
               case (req.data.opcode)
                  OP_STEP: begin
                     step_in = 1'b1;
                  end
                  OP_LOAD_POS: begin
                     px_in = req.data.value_x;
                     py_in = req.data.value_y;
                  end
                  OP_LOAD_VEL: begin
                     vx_in = req.data.value_x;
                     vy_in = req.data.value_y;
                  end
                  default: begin
                     step_in = 1'b0;
                  end
               endcase
               state_in = ST_SQX;
            end
         end
         ST_CHKX: begin
            if (u_done) begin
               sx_in    = u_res;
               state_in = ST_CHKY;
            end
         end
         ST_CHKY: begin
            u_start  = 1'b1;
            u_op     = FN_MUL;
            u_a      = 66'(ay);
            u_b      = 66'(ay);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (u_done) begin
               near_in = (ax < 33'(radius_ff)) && (ay < 33'(radius_ff)) &&
                         ((sx_ff + u_res) < r_sq);
               dist_in = sx_ff + u_res;
               if (step_ff && !near_in) begin
                  step_in  = 1'b0;
                  state_in = ST_SQRT;
                  u_start  = 1'b1;
                  u_op     = FN_SQRT;
                  u_a      = sx_ff + u_res;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_OUT;
               end
            end
         end
         ST_SQRT: begin
            if (u_done) begin
               dist_in = u_res;
               if (u_res == '0) begin
                  vx_in    = '0;
                  vy_in    = '0;
                  state_in = ST_SQX;
               end else begin
                  state_in = ST_MULX;
                  u_start  = 1'b1;
                  u_op     = FN_MUL;
                  u_a      = 66'(ax);
                  u_b      = 66'(speed_ff);
               end
            end
         end
         ST_SQX: begin
            // Starts the arrival check on the point as it now stands.
            u_start  = 1'b1;
            u_op     = FN_MUL;
            u_a      = 66'(ax);
            u_b      = 66'(ax);
            state_in = ST_CHKX;
         end
         ST_MULX: begin
            if (u_done) begin
               state_in = ST_DIVX;
               u_start  = 1'b1;
               u_op     = FN_DIV;
               u_a      = u_res;
               u_b      = dist_ff;
            end
         end
         ST_DIVX: begin
            if (u_done) begin
               qs       = dx[32] ? -33'(u_res[32:0]) : 33'(u_res[32:0]);
               vx_in    = qs[31:0];
               state_in = ST_MULY;
               u_start  = 1'b1;
               u_op     = FN_MUL;
               u_a      = 66'(ay);
               u_b      = 66'(speed_ff);
            end
         end
         ST_MULY: begin
            if (u_done) begin
               state_in = ST_DIVY;
               u_start  = 1'b1;
               u_op     = FN_DIV;
               u_a      = u_res;
               u_b      = dist_ff;
            end
         end
         ST_DIVY: begin
            if (u_done) begin
               qs       = dy[32] ? -33'(u_res[32:0]) : 33'(u_res[32:0]);
               vy_in    = qs[31:0];
               state_in = ST_SQY;
            end
         end
         ST_SQY: begin
            u_start  = 1'b1;
            u_op     = FN_MUL;
            u_a      = 66'(avx);
            u_b      = 66'(dt_ff);
            state_in = ST_MVX;
         end
         ST_MVX: begin
            if (u_done) begin
               sum_x    = vx_ff[31] ? 34'(px_ff) - 34'(u_res[65:16])
                                    : 34'(px_ff) + 34'(u_res[65:16]);
               px_in    = sat(sum_x);
               state_in = ST_MVY;
               u_start  = 1'b1;
               u_op     = FN_MUL;
               u_a      = 66'(avy);
               u_b      = 66'(dt_ff);
            end
         end
         ST_MVY: begin
            if (u_done) begin
               sum_y    = vy_ff[31] ? 34'(py_ff) - 34'(u_res[65:16])
                                    : 34'(py_ff) + 34'(u_res[65:16]);
               py_in    = sat(sum_y);
               state_in = ST_SQX;
            end
         end
         ST_OUT: begin
            if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.data.pos_x     = px_ff;
   assign rsp.data.pos_y     = py_ff;
   assign rsp.data.vel_x     = vx_ff;
   assign rsp.data.vel_y     = vy_ff;
   assign rsp.data.at_target = near_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= 1'b0;
         tx_ff        <= '0;
         ty_ff        <= '0;
         speed_ff     <= SpeedReset;
         radius_ff    <= RadiusReset;
         px_ff        <= '0;
         py_ff        <= '0;
         vx_ff        <= '0;
         vy_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         px_ff        <= px_in;
         py_ff        <= py_in;
         vx_ff        <= vx_in;
         vy_ff        <= vy_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TARGET_X: tx_ff     <= csr_write_data;
               CSR_TARGET_Y: ty_ff     <= csr_write_data;
               CSR_SPEED:    speed_ff  <= csr_write_data[SpeedWidth-1:0];
               CSR_RADIUS:   radius_ff <= csr_write_data[RadiusWidth-1:0];
               default:      tx_ff     <= tx_ff;
            endcase
         end
      end
      dt_ff   <= dt_in;
      sx_ff   <= sx_in;
      dist_ff <= dist_in;
      near_ff <= near_in;
   end

endmodule

// ===== tb/sv/seek_target_step_unit_tb.sv =====
// Testbench for seek_target_step_unit: directed and random requests with a
// predicting scoreboard class. Depends on sts_pkg, sts_stream_if and the RTL.
module seek_target_step_unit_tb;
   import sts_pkg::*;

   class seek_ledger;
      logic [31:0] tgt_x, tgt_y;
      logic [23:0] spd;
      logic [30:0] radius;
      logic [31:0] px, py, vx, vy;
      rsp_type     expected_q[$];
      int          mismatches;

      function new();
         tgt_x = '0;
         tgt_y = '0;
         spd = SpeedReset;
         radius = RadiusReset;
         px = '0;
         py = '0;
         vx = '0;
         vy = '0;
         mismatches = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_TARGET_X: tgt_x = value;
            CSR_TARGET_Y: tgt_y = value;
            CSR_SPEED:    spd = value[23:0];
            CSR_RADIUS:   radius = value[30:0];
            default: ;
         endcase
      endfunction

      function logic [32:0] offset(logic [31:0] t, logic [31:0] p);
         return {t[31], t} - {p[31], p};
      endfunction

      function logic [32:0] magnitude(logic [32:0] d);
         return d[32] ? (~d + 33'd1) : d;
      endfunction

      function logic [65:0] dist_squared();
         logic [65:0] ax, ay;
         ax = {33'b0, magnitude(offset(tgt_x, px))};
         ay = {33'b0, magnitude(offset(tgt_y, py))};
         return ax * ax + ay * ay;
      endfunction

      function logic arrived();
         logic [65:0] r;
         r = {35'b0, radius};
         return dist_squared() < r * r;
      endfunction

      function logic [33:0] floor_root(logic [65:0] v);
         logic [67:0] rem;
         logic [33:0] root;
         logic [67:0] trial;
         rem = '0;
         root = '0;
         for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | v[2*i +: 2];
            trial = {32'b0, root, 2'b01};
            if (rem >= trial) begin
               rem = rem - trial;
               root = {root[32:0], 1'b1};
            end else begin
               root = {root[32:0], 1'b0};
            end
         end
         return root;
      endfunction

      function logic [31:0] heading(logic [32:0] d, logic [33:0] span);
         logic [63:0] num, q;
         num = {31'b0, magnitude(d)} * {40'b0, spd};
         q = num / {30'b0, span};
         return d[32] ? -q[31:0] : q[31:0];
      endfunction

      function logic [31:0] advance(logic [31:0] p, logic [31:0] v, logic [23:0] dt);
         logic [31:0] av;
         longint      m, s;
         av = v[31] ? -v : v;
         m = longint'(({32'b0, av} * {40'b0, dt}) >> 16);
         s = v[31] ? longint'($signed(p)) - m : longint'($signed(p)) + m;
         if (s > 64'sd2147483647) s = 64'sd2147483647;
         if (s < -64'sd2147483648) s = -64'sd2147483648;
         return s[31:0];
      endfunction

      function void move_toward(logic [23:0] dt);
         logic [32:0] dx, dy;
         logic [33:0] span;
         if (arrived()) return;
         dx = offset(tgt_x, px);
         dy = offset(tgt_y, py);
         span = floor_root(dist_squared());
         if (span == 0) begin
            vx = '0;
            vy = '0;
            return;
         end
         vx = heading(dx, span);
         vy = heading(dy, span);
         px = advance(px, vx, dt);
         py = advance(py, vy, dt);
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         case (r.opcode)
            OP_STEP:     move_toward(r.delta_time);
            OP_LOAD_POS: begin
               px = r.value_x;
               py = r.value_y;
            end
            OP_LOAD_VEL: begin
               vx = r.value_x;
               vy = r.value_y;
            end
            default: ;
         endcase
         e.pos_x = px;
         e.pos_y = py;
         e.vel_x = vx;
         e.vel_y = vy;
         e.at_target = arrived();
         expected_q.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %h", got);
            return;
         end
         e = expected_q.pop_front();
         if (got.pos_x !== e.pos_x || got.pos_y !== e.pos_y || got.vel_x !== e.vel_x ||
             got.vel_y !== e.vel_y || got.at_target !== e.at_target) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch pos %h %h vel %h %h at %b, expected pos %h %h vel %h %h at %b",
                        got.pos_x, got.pos_y, got.vel_x, got.vel_y, got.at_target,
                        e.pos_x, e.pos_y, e.vel_x, e.vel_y, e.at_target);
         end
      endfunction
   endclass

   localparam longint CycleLimit = 4000000;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [CsrAddrWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_write_data;
   int          sender_idle_pct;
   int          receiver_stall_pct;
   int          hold_left;
   longint      cycles;
   seek_ledger  ledger;

   sts_stream_if #(.payload_type(req_type)) req_if ();
   sts_stream_if #(.payload_type(rsp_type)) rsp_if ();

   seek_target_step_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_if.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_if.ready = ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) ledger.check_result(rsp_if.data);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      ledger.set_reg(idx, value);
   endtask

   task automatic write_all(logic [31:0] tx, logic [31:0] ty, logic [23:0] sp,
                            logic [30:0] rad);
      write_reg(CSR_TARGET_X, tx);
      write_reg(CSR_TARGET_Y, ty);
      write_reg(CSR_SPEED, {8'b0, sp});
      write_reg(CSR_RADIUS, {1'b0, rad});
   endtask

   task automatic drain();
      while (ledger.expected_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic send(opcode_type op, logic [23:0] dt, logic [31:0] x, logic [31:0] y);
      req_type r;
      r.opcode = op;
      r.delta_time = dt;
      r.value_x = x;
      r.value_y = y;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.data = r;
      forever begin
         @(posedge clock);
         if (req_if.ready) break;
      end
      ledger.note_request(r);
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   function automatic logic [31:0] near_coord(logic [31:0] center);
      case ($urandom_range(3))
         0: return $urandom();
         1: return center + 32'($signed($urandom_range(2000)) - 1000);
         default: return center + 32'($signed($urandom_range(1 << 22)) - (1 << 21));
      endcase
   endfunction

   task automatic send_random();
      int          pick;
      logic [23:0] dt;
      pick = $urandom_range(99);
      dt = ($urandom_range(3) == 0) ? 24'($urandom()) : 24'($urandom_range(1 << 17));
      if (pick < 65)
         send(OP_STEP, dt, $urandom(), $urandom());
      else if (pick < 82)
         send(OP_LOAD_POS, 24'($urandom()), near_coord(ledger.tgt_x), near_coord(ledger.tgt_y));
      else if (pick < 94)
         send(OP_LOAD_VEL, 24'($urandom()), $urandom(), $urandom());
      else
         send(OP_NONE, 24'($urandom()), $urandom(), $urandom());
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      ledger = new();
      cycles = 0;
      hold_left = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      send(OP_STEP, 24'hff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send(OP_NONE, 24'hff_ffff, 32'h1234_5678, 32'h8765_4321);
      send(OP_LOAD_POS, 24'hff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      send(OP_STEP, 24'hff_ffff, 32'h0, 32'h0);
      send(OP_LOAD_VEL, 24'h0, 32'h8000_0000, 32'h7fff_ffff);
      send(OP_NONE, 24'h0, 32'h0, 32'h0);
      send(OP_LOAD_POS, 24'h0, 32'h0005_0000, 32'hfff9_0000);
      send(OP_STEP, 24'h01_0000, 32'hdead_beef, 32'h0bad_f00d);
      send(OP_STEP, 24'h0, 32'h0, 32'h0);
      send(OP_LOAD_POS, 24'h0, 32'h0, 32'h0);
      send(OP_STEP, 24'h01_0000, 32'h0, 32'h0);
      drain();
      write_all(32'd100, 32'd100, 24'h03_0000, 31'd0);
      send(OP_LOAD_POS, 24'h0, 32'd100, 32'd100);
      send(OP_STEP, 24'hff_ffff, 32'hffff_ffff, 32'h0);
      drain();
      write_all(32'h7fff_ffff, 32'h7fff_ffff, 24'hff_ffff, 31'd0);
      send(OP_LOAD_POS, 24'h0, 32'h7fff_fffa, 32'h7fff_fc17);
      send(OP_STEP, 24'hff_ffff, 32'h0, 32'h0);
      drain();
      write_all(32'h8000_0000, 32'h8000_0000, 24'hff_ffff, 31'd0);
      send(OP_LOAD_POS, 24'h0, 32'h8000_0003, 32'h8000_01f4);
      send(OP_STEP, 24'hff_ffff, 32'h0, 32'h0);
      drain();
      write_all(32'h0010_0000, 32'hfff0_0000, 24'h0, 31'h7fff_ffff);
      send(OP_STEP, 24'h02_0000, 32'h0, 32'h0);
      send(OP_LOAD_POS, 24'h0, 32'h8000_0000, 32'h7fff_ffff);
      send(OP_STEP, 24'h02_0000, 32'h0, 32'h0);
      drain();
      write_all(32'h0010_0000, 32'hfff0_0000, 24'h0, 31'h0001_0000);
      send(OP_STEP, 24'h02_0000, 32'h0, 32'h0);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         sender_idle_pct = (phase % 4 == 1 || phase % 4 == 3) ? ((phase % 4 == 1) ? 72 : 7) : 0;
         receiver_stall_pct = (phase % 4 == 2) ? 72 : ((phase % 4 == 3) ? 7 : 0);
         write_all(pick_coord(), pick_coord(),
                   ($urandom_range(4) == 0) ? 24'hff_ffff : 24'($urandom_range(1 << 20)),
                   ($urandom_range(4) == 0) ? 31'($urandom()) :
                                               31'($urandom_range(1 << 20)));
         for (int n = 0; n < 116; n++) begin
            if (phase == 2 && n == 30) hold_left = 3000;
            if (phase == 5 && n == 60) drain();
            send_random();
         end
         drain();
      end

      while (ledger.expected_q.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.expected_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// ===== files.f =====
sv/sts_pkg.sv
sv/sts_stream_if.sv
sv/sts_serial_unit.sv
sv/seek_target_step_unit.sv
tb/sv/seek_target_step_unit_tb.sv
